// File: sv/slmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmr_pkg
// shared constants, command and status codes, and interface structs for the
// two-list merge and reverse block
// ----------------------------------------------------------------------------
package slmr_pkg;

    localparam int A_DEPTH_DEF   = 64;
    localparam int B_DEPTH_DEF   = 32;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int ACT_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACT_W-1:0] ACT_APPEND_A = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND_B = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REVERSE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MERGE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic a_we;
        logic b_we;
    } slmr_wen_t;

    typedef struct packed {
        logic                valid;
        logic                last;
        logic [STATUS_W-1:0] status;
    } slmr_emit_t;

endpackage

// File: sv/slmr_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmr_store
// key storage: list a in two banks (live and scratch) and list b, each with
// one write port and one registered read port
// ----------------------------------------------------------------------------
module slmr_store #(
    parameter int A_DEPTH   = slmr_pkg::A_DEPTH_DEF,
    parameter int B_DEPTH   = slmr_pkg::B_DEPTH_DEF,
    parameter int KEY_WIDTH = slmr_pkg::KEY_WIDTH_DEF,
    localparam int AIW = $clog2(A_DEPTH),
    localparam int BIW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1
) (
    input  logic                  clk,
    input  slmr_pkg::slmr_wen_t   wen,
    input  logic [AIW:0]          a_waddr,
    input  logic [KEY_WIDTH-1:0]  a_wdata,
    input  logic [AIW:0]          a_raddr,
    output logic [KEY_WIDTH-1:0]  a_rdata,
    input  logic [BIW-1:0]        b_waddr,
    input  logic [KEY_WIDTH-1:0]  b_wdata,
    input  logic [BIW-1:0]        b_raddr,
    output logic [KEY_WIDTH-1:0]  b_rdata
);

    import slmr_pkg::*;

    localparam int A_WORDS = 2 ** (AIW + 1);
    localparam int B_WORDS = 2 ** BIW;

    logic [KEY_WIDTH-1:0] mem_a [0:A_WORDS-1];
    logic [KEY_WIDTH-1:0] mem_b [0:B_WORDS-1];

    always_ff @(posedge clk)
    begin
        if (wen.a_we)
        begin
            mem_a[a_waddr] <= a_wdata;
        end
        a_rdata <= mem_a[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.b_we)
        begin
            mem_b[b_waddr] <= b_wdata;
        end
        b_rdata <= mem_b[b_raddr];
    end

endmodule

// File: sv/slmr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmr_ctrl
// command sequencer: appends, bank-copy reverse, one-key-per-cycle merge
// through a shared signed compare, and readout of list a
// ----------------------------------------------------------------------------
module slmr_ctrl #(
    parameter int A_DEPTH   = slmr_pkg::A_DEPTH_DEF,
    parameter int B_DEPTH   = slmr_pkg::B_DEPTH_DEF,
    parameter int KEY_WIDTH = slmr_pkg::KEY_WIDTH_DEF,
    localparam int AIW = $clog2(A_DEPTH),
    localparam int BIW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [slmr_pkg::ACT_W-1:0]    action,
    input  logic [KEY_WIDTH-1:0]          in_key,
    input  logic                          out_free,
    output slmr_pkg::slmr_emit_t          emit,
    output logic [KEY_WIDTH-1:0]          emit_key,
    output slmr_pkg::slmr_wen_t           wen,
    output logic [AIW:0]                  a_waddr,
    output logic [KEY_WIDTH-1:0]          a_wdata,
    output logic [AIW:0]                  a_raddr,
    input  logic [KEY_WIDTH-1:0]          a_rdata,
    output logic [BIW-1:0]                b_waddr,
    output logic [KEY_WIDTH-1:0]          b_wdata,
    output logic [BIW-1:0]                b_raddr,
    input  logic [KEY_WIDTH-1:0]          b_rdata
);

    import slmr_pkg::*;

    localparam int CAW = $clog2(A_DEPTH + 1);
    localparam int BCW = $clog2(B_DEPTH + 1);
    localparam int SW  = ((CAW > BCW) ? CAW : BCW) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REV,
        S_MERGE,
        S_READ,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic                bank_reg, bank_next;
    logic [CAW-1:0]      a_count_reg, a_count_next;
    logic [BCW-1:0]      b_count_reg, b_count_next;
    logic [CAW-1:0]      i_reg, i_next;
    logic [BCW-1:0]      j_reg, j_next;
    logic [CAW-1:0]      k_reg, k_next;
    logic [CAW-1:0]      n_reg, n_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [SW-1:0]       sum_n;
    logic                a_less;
    logic                take_a;
    logic [CAW-1:0]      a_ridx;
    logic [BCW-1:0]      b_ridx;
    logic [CAW-1:0]      a_widx;
    logic [CAW-1:0]      rev_src;
    logic [CAW-1:0]      merge_dst;
    logic [CAW-1:0]      a_last_idx;

    assign sum_n      = SW'(a_count_reg) + SW'(b_count_reg);
    assign a_less     = $signed(a_rdata) < $signed(b_rdata);
    assign take_a     = (i_reg < a_count_reg) && ((j_reg >= b_count_reg) || a_less);
    assign rev_src    = a_count_reg - k_reg - CAW'(2);
    assign merge_dst  = n_reg - k_reg - CAW'(1);
    assign a_last_idx = a_count_reg - CAW'(1);

    assign in_ready = (state_reg == S_IDLE);
    assign a_raddr  = {bank_reg, a_ridx[AIW-1:0]};
    assign a_waddr  = {(state_reg == S_IDLE) ? bank_reg : ~bank_reg, a_widx[AIW-1:0]};
    assign b_raddr  = b_ridx[BIW-1:0];
    assign b_waddr  = b_count_reg[BIW-1:0];
    assign b_wdata  = in_key;
    assign emit_key = (state_reg == S_READ) ? a_rdata : '0;

    always_comb
    begin
        state_next   = state_reg;
        bank_next    = bank_reg;
        a_count_next = a_count_reg;
        b_count_next = b_count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        status_next  = status_reg;
        wen          = '0;
        a_widx       = k_reg;
        a_wdata      = a_rdata;
        a_ridx       = k_reg;
        b_ridx       = j_reg;
        emit         = '0;

        case (state_reg)
            S_IDLE:
            begin
                a_widx  = a_count_reg;
                a_wdata = in_key;
                if (in_valid)
                begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    k_next      = '0;
                    case (action)
                        ACT_APPEND_A:
                        begin
                            if (a_count_reg == CAW'(A_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wen.a_we     = 1'b1;
                                a_count_next = a_count_reg + CAW'(1);
                            end
                        end
                        ACT_APPEND_B:
                        begin
                            if (b_count_reg == BCW'(B_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wen.b_we     = 1'b1;
                                b_count_next = b_count_reg + BCW'(1);
                            end
                        end
                        ACT_REVERSE:
                        begin
                            a_ridx = a_last_idx;
                            if (a_count_reg > CAW'(1))
                            begin
                                state_next = S_REV;
                            end
                        end
                        ACT_MERGE:
                        begin
                            a_ridx = '0;
                            b_ridx = '0;
                            i_next = '0;
                            j_next = '0;
                            n_next = sum_n[CAW-1:0];
                            if (sum_n > SW'(A_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (sum_n != '0)
                            begin
                                state_next = S_MERGE;
                            end
                        end
                        ACT_READ:
                        begin
                            a_ridx = '0;
                            if (a_count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_REV:
            begin
                wen.a_we = 1'b1;
                a_widx   = k_reg;
                a_wdata  = a_rdata;
                a_ridx   = rev_src;
                if (k_reg == a_last_idx)
                begin
                    bank_next  = ~bank_reg;
                    state_next = S_RESP;
                end
                else
                begin
                    k_next = k_reg + CAW'(1);
                end
            end
            S_MERGE:
            begin
                wen.a_we = 1'b1;
                a_widx   = merge_dst;
                a_wdata  = take_a ? a_rdata : b_rdata;
                if (take_a)
                begin
                    i_next = i_reg + CAW'(1);
                end
                else
                begin
                    j_next = j_reg + BCW'(1);
                end
                a_ridx = i_next;
                b_ridx = j_next;
                k_next = k_reg + CAW'(1);
                if (k_reg == n_reg - CAW'(1))
                begin
                    bank_next    = ~bank_reg;
                    a_count_next = n_reg;
                    b_count_next = '0;
                    state_next   = S_RESP;
                end
            end
            S_READ:
            begin
                a_ridx = k_reg;
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.status = ST_OK;
                    emit.last   = (k_reg == a_last_idx);
                    if (k_reg == a_last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + CAW'(1);
                        a_ridx = k_next;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.last   = 1'b1;
                    emit.status = status_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bank_reg    <= 1'b0;
            a_count_reg <= '0;
            b_count_reg <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            n_reg       <= '0;
            status_reg  <= ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            a_count_reg <= a_count_next;
            b_count_reg <= b_count_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            n_reg       <= n_next;
            status_reg  <= status_next;
        end
    end

endmodule

// File: sv/sorted_list_merge_reverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_merge_reverse
// two bounded lists of signed fixed-point keys with append, reverse, merge
// and readout commands
//
// usage
// - slave channel: s_tuser carries the command, s_tdata the key for appends
// - master channel: one transfer per result; tdata key (readout only, zero
//   otherwise), tlast on the final transfer of a command, tuser status
// - one command at a time: s_tready is low from the accepting edge until the
//   command's final result has been loaded into the output register
// - appends and ignored codes: the result is sent from the response state
// - reverse: one key copied per cycle into the spare bank
// - merge: one key per cycle through the
//   signed compare and the single write port of list a
// - readout: one key per cycle after the accepting edge, paced by the list a
//   read port and by m_tready
// - a stalled receiver holds the output register; the sequencer waits
// - after reset both lists are empty and the block is ready
// ----------------------------------------------------------------------------
module sorted_list_merge_reverse #(
    parameter int A_DEPTH   = slmr_pkg::A_DEPTH_DEF,
    parameter int B_DEPTH   = slmr_pkg::B_DEPTH_DEF,
    parameter int KEY_WIDTH = slmr_pkg::KEY_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [slmr_pkg::DATA_W-1:0]       s_tdata,   // key_in
    input  logic [slmr_pkg::ACT_W-1:0]        s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [slmr_pkg::DATA_W-1:0]       m_tdata,   // key_out
    output logic                              m_tlast,
    output logic [slmr_pkg::STATUS_W-1:0]     m_tuser    // status
);

    import slmr_pkg::*;

    localparam int AIW = $clog2(A_DEPTH);
    localparam int BIW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

    logic [KEY_WIDTH+DATA_W-1:0] key_in_ext;
    logic [KEY_WIDTH-1:0]        in_key;
    logic [KEY_WIDTH+DATA_W-1:0] key_out_ext;
    logic [KEY_WIDTH-1:0]        emit_key;
    slmr_emit_t                  emit;
    slmr_wen_t                   wen;
    logic [AIW:0]                a_waddr;
    logic [AIW:0]                a_raddr;
    logic [KEY_WIDTH-1:0]        a_wdata;
    logic [KEY_WIDTH-1:0]        a_rdata;
    logic [BIW-1:0]              b_waddr;
    logic [BIW-1:0]              b_raddr;
    logic [KEY_WIDTH-1:0]        b_wdata;
    logic [KEY_WIDTH-1:0]        b_rdata;
    logic                        out_free;

    logic                        m_tvalid_reg;
    logic [DATA_W-1:0]           m_tdata_reg;
    logic                        m_tlast_reg;
    logic [STATUS_W-1:0]         m_tuser_reg;

    assign key_in_ext  = {{KEY_WIDTH{1'b0}}, s_tdata};
    assign in_key      = key_in_ext[KEY_WIDTH-1:0];
    assign key_out_ext = {{DATA_W{1'b0}}, emit_key};
    assign out_free    = !m_tvalid_reg || m_tready;

    slmr_ctrl #(
        .A_DEPTH   (A_DEPTH),
        .B_DEPTH   (B_DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .action   (s_tuser),
        .in_key   (in_key),
        .out_free (out_free),
        .emit     (emit),
        .emit_key (emit_key),
        .wen      (wen),
        .a_waddr  (a_waddr),
        .a_wdata  (a_wdata),
        .a_raddr  (a_raddr),
        .a_rdata  (a_rdata),
        .b_waddr  (b_waddr),
        .b_wdata  (b_wdata),
        .b_raddr  (b_raddr),
        .b_rdata  (b_rdata)
    );

    slmr_store #(
        .A_DEPTH   (A_DEPTH),
        .B_DEPTH   (B_DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_store (
        .clk     (clk),
        .wen     (wen),
        .a_waddr (a_waddr),
        .a_wdata (a_wdata),
        .a_raddr (a_raddr),
        .a_rdata (a_rdata),
        .b_waddr (b_waddr),
        .b_wdata (b_wdata),
        .b_raddr (b_raddr),
        .b_rdata (b_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            m_tdata_reg <= key_out_ext[DATA_W-1:0];
            m_tlast_reg <= emit.last;
            m_tuser_reg <= emit.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: sv/slmr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmr_checker
// port-level checks on the command handshake and on result status coding
// ----------------------------------------------------------------------------
module slmr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [slmr_pkg::DATA_W-1:0]   m_tdata,
    input logic                          m_tlast,
    input logic [slmr_pkg::STATUS_W-1:0] m_tuser
);

    import slmr_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // one command in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in progress");

    // only readout gives more than one transfer, all ok
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == ST_OK)
        else $error("non-final transfer with error status");

    // empty readout carries a zero key
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata == '0)
        else $error("empty readout with nonzero key");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_EMPTY)
        else $error("undefined status code");

endmodule

bind sorted_list_merge_reverse slmr_checker u_slmr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the two-list merge and reverse block: commands go
// in on the slave stream with random gaps, results are taken off the master
// stream under random back-pressure and compared field by field against a
// behavioural copy of both lists kept in a small scoreboard class
// ----------------------------------------------------------------------------
module testbench;

    import slmr_pkg::*;

    localparam int A_DEPTH     = A_DEPTH_DEF;
    localparam int B_DEPTH     = B_DEPTH_DEF;
    localparam int KEY_WIDTH   = KEY_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_ITEMS = 185;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] KEY_MAX = 32'h7fff_ffff;

    typedef struct {
        logic [DATA_W-1:0]   key;
        logic                last;
        logic [STATUS_W-1:0] status;
    } list_result_t;

    class list_scoreboard;
        logic [KEY_WIDTH-1:0] a_keys[A_DEPTH];
        logic [KEY_WIDTH-1:0] b_keys[B_DEPTH];
        int                   a_count;
        int                   b_count;
        list_result_t         pending_q[$];
        int                   failures;

        function new();
            a_count  = 0;
            b_count  = 0;
            failures = 0;
        endfunction

        function void push_result(logic [KEY_WIDTH-1:0] key, logic last,
                                  logic [STATUS_W-1:0] status);
            list_result_t r;
            r.key    = DATA_W'(key);
            r.last   = last;
            r.status = status;
            pending_q.push_back(r);
        endfunction

        function logic [STATUS_W-1:0] merge_b_into_a();
            logic [KEY_WIDTH-1:0] merged[A_DEPTH];
            logic [KEY_WIDTH-1:0] key;
            int n;
            int i;
            int j;
            n = a_count + b_count;
            if (n > A_DEPTH)
                return ST_FULL;
            i = 0;
            j = 0;
            for (int k = 0; k < n; k++)
            begin
                if (i < a_count && (j >= b_count || $signed(a_keys[i]) < $signed(b_keys[j])))
                begin
                    key = a_keys[i];
                    i++;
                end
                else
                begin
                    key = b_keys[j];
                    j++;
                end
                merged[n - 1 - k] = key;
            end
            for (int k = 0; k < n; k++)
                a_keys[k] = merged[k];
            a_count = n;
            b_count = 0;
            return ST_OK;
        endfunction

        function void note_command(logic [ACT_W-1:0] act, logic [DATA_W-1:0] key_in);
            logic [STATUS_W-1:0]  st;
            logic [KEY_WIDTH-1:0] key;
            logic [KEY_WIDTH-1:0] t;
            st  = ST_OK;
            key = key_in[KEY_WIDTH-1:0];
            case (act)
                ACT_APPEND_A:
                    if (a_count >= A_DEPTH)
                        st = ST_FULL;
                    else
                    begin
                        a_keys[a_count] = key;
                        a_count++;
                    end
                ACT_APPEND_B:
                    if (b_count >= B_DEPTH)
                        st = ST_FULL;
                    else
                    begin
                        b_keys[b_count] = key;
                        b_count++;
                    end
                ACT_REVERSE:
                    for (int k = 0; k < a_count / 2; k++)
                    begin
                        t = a_keys[k];
                        a_keys[k] = a_keys[a_count - 1 - k];
                        a_keys[a_count - 1 - k] = t;
                    end
                ACT_MERGE:
                    st = merge_b_into_a();
                ACT_READ:
                begin
                    if (a_count == 0)
                        push_result('0, 1'b1, ST_EMPTY);
                    else
                        for (int k = 0; k < a_count; k++)
                            push_result(a_keys[k], k == a_count - 1, ST_OK);
                    return;
                end
                default: ;
            endcase
            push_result('0, 1'b1, st);
        endfunction

        function void check_result(logic [DATA_W-1:0] key, logic last,
                                   logic [STATUS_W-1:0] status);
            list_result_t exp_r;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: key_out %h last %b status %0d", key, last, status);
                failures++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (key !== exp_r.key)
            begin
                $error("key_out mismatch: expected %h, actual %h", exp_r.key, key);
                failures++;
            end
            if (last !== exp_r.last)
            begin
                $error("last mismatch: expected %b, actual %b", exp_r.last, last);
                failures++;
            end
            if (status !== exp_r.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", exp_r.status, status);
                failures++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;
    logic [ACT_W-1:0]    s_tuser  = ACT_APPEND_A;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic                m_tlast;
    logic [STATUS_W-1:0] m_tuser;

    list_scoreboard lists = new();
    int             cycles     = 0;
    int             sent       = 0;
    int             next_gap   = 0;
    bit             steady     = 1'b0;

    sorted_list_merge_reverse dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            lists.check_result(m_tdata, m_tlast, m_tuser);
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return DATA_W'($signed($urandom_range(0, 4)) - 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] key);
        repeat (next_gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        lists.note_command(act, key);
        sent++;
        next_gap = pick_gap();
        if (next_gap != 0)
            s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        if (next_gap == 0)
            s_tvalid <= 1'b0;
        next_gap = 0;
        while (lists.pending() != 0)
            @(posedge clk);
    endtask

    // sorted runs into b (and sometimes a), sometimes a reverse, then merge and often a readout
    task automatic merge_run();
        logic signed [DATA_W-1:0] run_q[$];
        int nb;
        int na;
        nb = $urandom_range(1, 4);
        na = $urandom_range(0, 2);
        run_q.delete();
        for (int k = 0; k < nb; k++)
            run_q.push_back(pick_key());
        run_q.sort();
        foreach (run_q[k])
            send_cmd(ACT_APPEND_B, run_q[k]);
        run_q.delete();
        for (int k = 0; k < na; k++)
            run_q.push_back(pick_key());
        run_q.sort();
        foreach (run_q[k])
            send_cmd(ACT_APPEND_A, run_q[k]);
        if ($urandom_range(0, 3) == 0)
            send_cmd(ACT_REVERSE, pick_key());
        send_cmd(ACT_MERGE, pick_key());
        if ($urandom_range(0, 1) == 0)
            send_cmd(ACT_READ, pick_key());
    endtask

    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        int r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty lists, single keys, extremes, ties and spare codes
        send_cmd(ACT_READ, KEY_MAX);
        send_cmd(ACT_REVERSE, '0);
        send_cmd(ACT_MERGE, '0);
        send_cmd(ACT_APPEND_B, KEY_MAX);
        send_cmd(ACT_APPEND_B, KEY_MIN);
        send_cmd(ACT_MERGE, '0);
        send_cmd(ACT_READ, '0);
        send_cmd(ACT_REVERSE, '0);
        send_cmd(ACT_READ, '0);
        send_cmd(ACT_MERGE, '0);
        send_cmd(ACT_APPEND_A, '0);
        send_cmd(ACT_APPEND_B, '0);
        send_cmd(ACT_APPEND_B, 32'd1);
        send_cmd(ACT_MERGE, '0);
        send_cmd(ACT_READ, '0);
        for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            send_cmd(ACT_W'(a), 32'hffff_ffff);
        send_cmd(ACT_REVERSE, '0);
        send_cmd(ACT_READ, '0);
        drain();

        while (sent < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 9);
            if (r < 5)
                merge_run();
            else if (r < 8)
                send_cmd(ACT_W'($urandom_range(0, 7)), pick_key());
            else
                send_cmd(ACT_READ, pick_key());
            if ($urandom_range(0, 7) == 0)
                drain();
        end
        steady = 1'b0;
        drain();

        // fill both lists past their limits and merge into a full list
        while (lists.b_count < B_DEPTH)
            send_cmd(ACT_APPEND_B, pick_key());
        send_cmd(ACT_APPEND_B, pick_key());
        while (lists.a_count < A_DEPTH)
            send_cmd(ACT_APPEND_A, pick_key());
        send_cmd(ACT_APPEND_A, pick_key());
        send_cmd(ACT_MERGE, '0);
        send_cmd(ACT_REVERSE, '0);
        send_cmd(ACT_READ, '0);

        drain();
        repeat (A_DEPTH + 10) @(posedge clk);
        if (lists.failures == 0 && lists.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: files.f
sv/slmr_pkg.sv
sv/slmr_store.sv
sv/slmr_ctrl.sv
sv/sorted_list_merge_reverse.sv
sv/slmr_checker.sv
verif/testbench.sv
